[rtl/core/rsi_pkg.sv]
// ============================================================================
// rsi_pkg: shared types and widths of the ray and sphere intersection core
// Coordinate format, internal word widths, status codes, register indexes.
// ============================================================================
package rsi_pkg;

    // coordinate word and normalized direction magnitude
    localparam int CW       = 32;
    localparam int DIR_BITS = ((60 - CW) < 30) ? (60 - CW) : 30;
    localparam int WW       = CW + 1;            // origin minus center
    localparam int RW       = CW - 1;            // radius
    localparam int EW       = DIR_BITS;          // direction magnitude
    localparam int ESW      = EW + 1;            // signed direction

    // quadratic terms
    localparam int A_W   = 2 * EW + 2;           // |e|^2
    localparam int B_W   = 64;                   // w.e
    localparam int CR_W  = WW + ESW;             // cross product component
    localparam int CRM_W = CR_W - 1;             // its magnitude
    localparam int D_W   = 2 * EW + 2 * RW + 2;  // discriminant
    localparam int S_W   = D_W / 2;              // its square root

    // numerators and quotients
    localparam int NUM_W = 64;
    localparam int NM_W  = NUM_W - 1;
    localparam int N_W   = EW + NM_W;
    localparam int Q_W   = N_W - 2 * (EW - 1);

    typedef enum logic [1:0] {
        ST_HIT   = 2'd0,
        ST_MISS  = 2'd1,
        ST_DEGEN = 2'd2
    } hit_status_t;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_t;

endpackage

[rtl/core/rsi_sqrt_pipe.sv]
// ============================================================================
// rsi_sqrt_pipe: pipelined integer square root
// One root bit per stage, floor result, side data travels with each item.
// ============================================================================
module rsi_sqrt_pipe #(
    parameter int RAD_W  = rsi_pkg::D_W,
    parameter int ROOT_W = RAD_W / 2,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int TW = RAD_W + 2;

    logic              vld_reg  [ROOT_W];
    logic [RAD_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        localparam int K = ROOT_W - 1 - j;
        logic              vld_in;
        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SIDE_W-1:0] side_in;
        logic [TW-1:0]     trial;
        logic              fits;

        if (j == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = in_rad;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        // try setting root bit K: (R + 2^K)^2 - R^2 = R*2^(K+1) + 2^(2K)
        assign trial = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
        assign fits  = TW'(rem_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= fits ? RAD_W'(TW'(rem_in) - trial) : rem_in;
                root_reg[j] <= fits ? (root_in | (ROOT_W'(1) << K)) : root_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];
    assign out_side = side_reg[ROOT_W-1];

endmodule

[rtl/core/rsi_div_pipe.sv]
// ============================================================================
// rsi_div_pipe: pipelined restoring divider
// One quotient bit per stage, truncated quotient, side data travels along.
// ============================================================================
module rsi_div_pipe #(
    parameter int NUM_W  = rsi_pkg::N_W,
    parameter int DEN_W  = rsi_pkg::A_W,
    parameter int QUO_W  = rsi_pkg::Q_W,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);
    localparam int TW = (DEN_W + QUO_W > NUM_W) ? (DEN_W + QUO_W) : NUM_W;

    logic              vld_reg  [QUO_W];
    logic [NUM_W-1:0]  rem_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_stage
        localparam int K = QUO_W - 1 - j;
        logic              vld_in;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_in;
        logic [TW-1:0]     trial;
        logic              fits;

        if (j == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = in_num;
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        // subtract the shifted divisor when it fits
        assign trial = TW'(den_in) << K;
        assign fits  = TW'(rem_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= fits ? NUM_W'(TW'(rem_in) - trial) : rem_in;
                den_reg[j]  <= den_in;
                quo_reg[j]  <= fits ? (quo_in | (QUO_W'(1) << K)) : quo_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign out_quo  = quo_reg[QUO_W-1];
    assign out_side = side_reg[QUO_W-1];

endmodule

[rtl/core/ray_sphere_intersection_core.sv]
// ============================================================================
// ray_sphere_intersection_core: ray against sphere, near and far hit points
// Fixed point Q16.16 ray and sphere intersection with saturated results.
// ============================================================================
// The core takes one ray item per clock while the pipeline is not held and
// returns one result item per ray, in order. Registered stages form the
// quadratic terms and the discriminant, the bit-per-stage square root of the
// 120-bit discriminant follows, registered stages then form the numerators,
// then come the bit-per-stage dividers (six in parallel, one per axis and
// root), and the output stage adds, saturates and loads the output
// register. The whole pipeline advances together; it holds while a result
// sits in the output register and is not taken. Hit points are relative to
// the sphere center. Status is hit, miss (negative discriminant) or degenerate
// (zero direction); the points are zero unless the ray hits. The user must write
// center and radius registers only while the core is empty; the core does not check.
module ray_sphere_intersection_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_addr,
    input  logic [rsi_pkg::CW-1:0]        cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [rsi_pkg::CW-1:0] origin_x,
    input  logic signed [rsi_pkg::CW-1:0] origin_y,
    input  logic signed [rsi_pkg::CW-1:0] origin_z,
    input  logic signed [rsi_pkg::CW-1:0] dir_x,
    input  logic signed [rsi_pkg::CW-1:0] dir_y,
    input  logic signed [rsi_pkg::CW-1:0] dir_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    hit_status,
    output logic signed [rsi_pkg::CW-1:0] near_x,
    output logic signed [rsi_pkg::CW-1:0] near_y,
    output logic signed [rsi_pkg::CW-1:0] near_z,
    output logic signed [rsi_pkg::CW-1:0] far_x,
    output logic signed [rsi_pkg::CW-1:0] far_y,
    output logic signed [rsi_pkg::CW-1:0] far_z
);
    import rsi_pkg::*;

    localparam int POS_W  = $clog2(CW);
    localparam int CR_LO  = (CRM_W + 1) / 2;
    localparam int CR_HI  = CRM_W - CR_LO;
    localparam int LO_W   = 32;
    localparam int AH_W   = A_W - LO_W;
    localparam int RH_W   = 2 * RW - LO_W;
    localparam int SQ_W   = 2 * CRM_W;
    localparam int QS_W   = SQ_W + 2;
    localparam int NH_W   = NM_W - LO_W;
    localparam int PT_W   = Q_W + 3;
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};
    localparam logic signed [PT_W-1:0] SAT_HI = {{(PT_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [PT_W-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        hit_status_t               status;
        logic [A_W-1:0]            a;
        logic signed [B_W-1:0]     b;
        logic [2:0][EW-1:0]        emag;
        logic [2:0]                dneg;
        logic [2:0][WW-1:0]        w;
    } sq_side_t;

    typedef struct packed {
        hit_status_t    status;
        logic           neg;
        logic [WW-1:0]  w;
    } dv_side_t;

    logic en;

    // configuration registers
    logic signed [CW-1:0] center_reg [3];
    logic [RW-1:0]        radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= RW'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_CENTER_X: center_reg[0] <= cfg_wdata;
                REG_CENTER_Y: center_reg[1] <= cfg_wdata;
                REG_CENTER_Z: center_reg[2] <= cfg_wdata;
                REG_RADIUS:   radius_reg    <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // advance everything unless a result waits in the output register and is not taken
    logic out_vld_reg;
    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    // ---------------- stage valid bits ----------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic s7_vld_reg, s8_vld_reg, s9_vld_reg, s10_vld_reg, s11_vld_reg;
    logic s12_vld_reg, s13_vld_reg, s14_vld_reg, s15_vld_reg;
    logic sq_vld;
    logic div_vld [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            s14_vld_reg <= 1'b0;
            s15_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= sq_vld;
            s13_vld_reg <= s12_vld_reg;
            s14_vld_reg <= s13_vld_reg;
            s15_vld_reg <= s14_vld_reg;
            out_vld_reg <= div_vld[0];
        end
    end

    // ---------------- stage 1: offset from center, direction magnitude ----------------
    logic signed [WW-1:0] s1_w_reg [3];
    logic [2:0]           s1_dneg_reg;
    logic [CW-1:0]        s1_dmag_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_w_reg[i]    <= WW'(org[i]) - WW'(center_reg[i]);
                s1_dneg_reg[i] <= dir[i][CW-1];
                s1_dmag_reg[i] <= dir[i][CW-1] ? CW'(-dir[i]) : CW'(dir[i]);
            end
        end
    end

    // ---------------- stage 2: largest direction component ----------------
    logic signed [WW-1:0] s2_w_reg [3];
    logic [2:0]           s2_dneg_reg;
    logic [CW-1:0]        s2_dmag_reg [3];
    logic [CW-1:0]        s2_m_reg;
    logic [CW-1:0]        s2_m01;

    assign s2_m01 = (s1_dmag_reg[0] > s1_dmag_reg[1]) ? s1_dmag_reg[0] : s1_dmag_reg[1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_w_reg    <= s1_w_reg;
            s2_dneg_reg <= s1_dneg_reg;
            s2_dmag_reg <= s1_dmag_reg;
            s2_m_reg    <= (s2_m01 > s1_dmag_reg[2]) ? s2_m01 : s1_dmag_reg[2];
        end
    end

    // ---------------- stage 3: normalizing shift from the leading one ----------------
    logic signed [WW-1:0] s3_w_reg [3];
    logic [2:0]           s3_dneg_reg;
    logic [CW-1:0]        s3_dmag_reg [3];
    logic                 s3_big_reg;
    logic [POS_W-1:0]     s3_sh_reg;
    logic                 s3_zero_reg;
    logic [POS_W-1:0]     s3_pos;
    logic                 s3_big;

    always_comb
    begin
        s3_pos = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (s2_m_reg[i])
                s3_pos = POS_W'(i);
        end
        s3_big = int'(s3_pos) >= EW;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_w_reg    <= s2_w_reg;
            s3_dneg_reg <= s2_dneg_reg;
            s3_dmag_reg <= s2_dmag_reg;
            s3_big_reg  <= s3_big;
            s3_sh_reg   <= s3_big ? POS_W'(int'(s3_pos) - (EW - 1))
                                  : POS_W'((EW - 1) - int'(s3_pos));
            s3_zero_reg <= (s2_m_reg == '0);
        end
    end

    // ---------------- stage 4: scaled direction ----------------
    logic signed [WW-1:0]  s4_w_reg [3];
    logic [2:0]            s4_dneg_reg;
    logic [EW-1:0]         s4_emag_reg [3];
    logic signed [ESW-1:0] s4_es_reg [3];
    logic                  s4_zero_reg;
    logic [EW-1:0]         s4_emag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_emag[i] = s3_big_reg ? EW'(s3_dmag_reg[i] >> s3_sh_reg)
                                    : EW'(s3_dmag_reg[i] << s3_sh_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_w_reg    <= s3_w_reg;
            s4_dneg_reg <= s3_dneg_reg;
            s4_zero_reg <= s3_zero_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_emag_reg[i] <= s4_emag[i];
                s4_es_reg[i]   <= s3_dneg_reg[i] ? -$signed({1'b0, s4_emag[i]})
                                                 : $signed({1'b0, s4_emag[i]});
            end
        end
    end

    // ---------------- stage 5: products ----------------
    logic signed [WW-1:0]   s5_w_reg [3];
    logic [2:0]             s5_dneg_reg;
    logic [EW-1:0]          s5_emag_reg [3];
    logic                   s5_zero_reg;
    logic [2*EW-1:0]        s5_ee_reg [3];
    logic signed [CR_W-1:0] s5_we_reg [3];
    logic signed [CR_W-1:0] s5_xa_reg [3];
    logic signed [CR_W-1:0] s5_xb_reg [3];
    logic [2*RW-1:0]        s5_r2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_w_reg    <= s4_w_reg;
            s5_dneg_reg <= s4_dneg_reg;
            s5_emag_reg <= s4_emag_reg;
            s5_zero_reg <= s4_zero_reg;
            s5_r2_reg   <= (2*RW)'(radius_reg) * (2*RW)'(radius_reg);
            for (int i = 0; i < 3; i++)
            begin
                s5_ee_reg[i] <= (2*EW)'(s4_emag_reg[i]) * (2*EW)'(s4_emag_reg[i]);
                s5_we_reg[i] <= CR_W'(s4_w_reg[i]) * CR_W'(s4_es_reg[i]);
                s5_xa_reg[i] <= CR_W'(s4_w_reg[NXT[i]]) * CR_W'(s4_es_reg[PRV[i]]);
                s5_xb_reg[i] <= CR_W'(s4_w_reg[PRV[i]]) * CR_W'(s4_es_reg[NXT[i]]);
            end
        end
    end

    // ---------------- stage 6: A, b and cross product ----------------
    logic signed [WW-1:0]   s6_w_reg [3];
    logic [2:0]             s6_dneg_reg;
    logic [EW-1:0]          s6_emag_reg [3];
    logic                   s6_zero_reg;
    logic [A_W-1:0]         s6_a_reg;
    logic signed [B_W-1:0]  s6_b_reg;
    logic signed [CR_W-1:0] s6_cr_reg [3];
    logic [2*RW-1:0]        s6_r2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_w_reg    <= s5_w_reg;
            s6_dneg_reg <= s5_dneg_reg;
            s6_emag_reg <= s5_emag_reg;
            s6_zero_reg <= s5_zero_reg;
            s6_r2_reg   <= s5_r2_reg;
            s6_a_reg    <= A_W'(s5_ee_reg[0]) + A_W'(s5_ee_reg[1]) + A_W'(s5_ee_reg[2]);
            s6_b_reg    <= B_W'(s5_we_reg[0]) + B_W'(s5_we_reg[1]) + B_W'(s5_we_reg[2]);
            for (int i = 0; i < 3; i++)
                s6_cr_reg[i] <= s5_xa_reg[i] - s5_xb_reg[i];
        end
    end

    // ---------------- stage 7: cross product magnitudes ----------------
    logic signed [WW-1:0]  s7_w_reg [3];
    logic [2:0]            s7_dneg_reg;
    logic [EW-1:0]         s7_emag_reg [3];
    logic                  s7_zero_reg;
    logic [A_W-1:0]        s7_a_reg;
    logic signed [B_W-1:0] s7_b_reg;
    logic [CRM_W-1:0]      s7_crm_reg [3];
    logic [2*RW-1:0]       s7_r2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_w_reg    <= s6_w_reg;
            s7_dneg_reg <= s6_dneg_reg;
            s7_emag_reg <= s6_emag_reg;
            s7_zero_reg <= s6_zero_reg;
            s7_a_reg    <= s6_a_reg;
            s7_b_reg    <= s6_b_reg;
            s7_r2_reg   <= s6_r2_reg;
            for (int i = 0; i < 3; i++)
                s7_crm_reg[i] <= s6_cr_reg[i][CR_W-1] ? CRM_W'(-s6_cr_reg[i])
                                                      : CRM_W'(s6_cr_reg[i]);
        end
    end

    // ---------------- stage 8: partial products of the squares ----------------
    logic signed [WW-1:0]  s8_w_reg [3];
    logic [2:0]            s8_dneg_reg;
    logic [EW-1:0]         s8_emag_reg [3];
    logic                  s8_zero_reg;
    logic [A_W-1:0]        s8_a_reg;
    logic signed [B_W-1:0] s8_b_reg;
    logic [2*CR_HI-1:0]    s8_hh_reg [3];
    logic [CRM_W-1:0]      s8_hl_reg [3];
    logic [2*CR_LO-1:0]    s8_ll_reg [3];
    logic [AH_W+RH_W-1:0]  s8_phh_reg;
    logic [AH_W+LO_W-1:0]  s8_phl_reg;
    logic [LO_W+RH_W-1:0]  s8_plh_reg;
    logic [2*LO_W-1:0]     s8_pll_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_w_reg    <= s7_w_reg;
            s8_dneg_reg <= s7_dneg_reg;
            s8_emag_reg <= s7_emag_reg;
            s8_zero_reg <= s7_zero_reg;
            s8_a_reg    <= s7_a_reg;
            s8_b_reg    <= s7_b_reg;
            for (int i = 0; i < 3; i++)
            begin
                s8_hh_reg[i] <= (2*CR_HI)'(s7_crm_reg[i][CRM_W-1:CR_LO])
                              * (2*CR_HI)'(s7_crm_reg[i][CRM_W-1:CR_LO]);
                s8_hl_reg[i] <= CRM_W'(s7_crm_reg[i][CRM_W-1:CR_LO])
                              * CRM_W'(s7_crm_reg[i][CR_LO-1:0]);
                s8_ll_reg[i] <= (2*CR_LO)'(s7_crm_reg[i][CR_LO-1:0])
                              * (2*CR_LO)'(s7_crm_reg[i][CR_LO-1:0]);
            end
            s8_phh_reg <= (AH_W+RH_W)'(s7_a_reg[A_W-1:LO_W])
                        * (AH_W+RH_W)'(s7_r2_reg[2*RW-1:LO_W]);
            s8_phl_reg <= (AH_W+LO_W)'(s7_a_reg[A_W-1:LO_W])
                        * (AH_W+LO_W)'(s7_r2_reg[LO_W-1:0]);
            s8_plh_reg <= (LO_W+RH_W)'(s7_a_reg[LO_W-1:0])
                        * (LO_W+RH_W)'(s7_r2_reg[2*RW-1:LO_W]);
            s8_pll_reg <= (2*LO_W)'(s7_a_reg[LO_W-1:0])
                        * (2*LO_W)'(s7_r2_reg[LO_W-1:0]);
        end
    end

    // ---------------- stage 9: squares and |e|^2 r^2 ----------------
    logic signed [WW-1:0]  s9_w_reg [3];
    logic [2:0]            s9_dneg_reg;
    logic [EW-1:0]         s9_emag_reg [3];
    logic                  s9_zero_reg;
    logic [A_W-1:0]        s9_a_reg;
    logic signed [B_W-1:0] s9_b_reg;
    logic [SQ_W-1:0]       s9_sq_reg [3];
    logic [D_W-1:0]        s9_p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_w_reg    <= s8_w_reg;
            s9_dneg_reg <= s8_dneg_reg;
            s9_emag_reg <= s8_emag_reg;
            s9_zero_reg <= s8_zero_reg;
            s9_a_reg    <= s8_a_reg;
            s9_b_reg    <= s8_b_reg;
            for (int i = 0; i < 3; i++)
                s9_sq_reg[i] <= (SQ_W'(s8_hh_reg[i]) << (2 * CR_LO))
                              + (SQ_W'(s8_hl_reg[i]) << (CR_LO + 1))
                              + SQ_W'(s8_ll_reg[i]);
            s9_p_reg <= (D_W'(s8_phh_reg) << (2 * LO_W))
                      + (D_W'(s8_phl_reg) << LO_W)
                      + (D_W'(s8_plh_reg) << LO_W)
                      + D_W'(s8_pll_reg);
        end
    end

    // ---------------- stage 10: |w x e|^2 ----------------
    logic signed [WW-1:0]  s10_w_reg [3];
    logic [2:0]            s10_dneg_reg;
    logic [EW-1:0]         s10_emag_reg [3];
    logic                  s10_zero_reg;
    logic [A_W-1:0]        s10_a_reg;
    logic signed [B_W-1:0] s10_b_reg;
    logic [QS_W-1:0]       s10_q_reg;
    logic [D_W-1:0]        s10_p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_w_reg    <= s9_w_reg;
            s10_dneg_reg <= s9_dneg_reg;
            s10_emag_reg <= s9_emag_reg;
            s10_zero_reg <= s9_zero_reg;
            s10_a_reg    <= s9_a_reg;
            s10_b_reg    <= s9_b_reg;
            s10_p_reg    <= s9_p_reg;
            s10_q_reg    <= QS_W'(s9_sq_reg[0]) + QS_W'(s9_sq_reg[1]) + QS_W'(s9_sq_reg[2]);
        end
    end

    // ---------------- stage 11: discriminant and status ----------------
    sq_side_t       s11_side_reg;
    logic [D_W-1:0] s11_d_reg;
    logic           s11_miss;

    assign s11_miss = QS_W'(s10_p_reg) < s10_q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_d_reg <= D_W'(QS_W'(s10_p_reg) - s10_q_reg);
            if (s10_zero_reg)
                s11_side_reg.status <= ST_DEGEN;
            else if (s11_miss)
                s11_side_reg.status <= ST_MISS;
            else
                s11_side_reg.status <= ST_HIT;
            s11_side_reg.a    <= s10_a_reg;
            s11_side_reg.b    <= s10_b_reg;
            s11_side_reg.dneg <= s10_dneg_reg;
            for (int i = 0; i < 3; i++)
            begin
                s11_side_reg.emag[i] <= s10_emag_reg[i];
                s11_side_reg.w[i]    <= s10_w_reg[i];
            end
        end
    end

    // ---------------- square root of the discriminant ----------------
    logic [S_W-1:0] sq_root;
    sq_side_t       sq_side;

    rsi_sqrt_pipe #(
        .RAD_W  (D_W),
        .ROOT_W (S_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s11_vld_reg),
        .in_rad   (s11_d_reg),
        .in_side  (s11_side_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // ---------------- stage 12: near and far numerators ----------------
    sq_side_t                s12_side_reg;
    logic signed [NUM_W-1:0] s12_num_reg [2];
    logic signed [NUM_W-1:0] s12_root;

    assign s12_root = $signed(NUM_W'(sq_root));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s12_side_reg   <= sq_side;
            s12_num_reg[0] <= -NUM_W'(sq_side.b) - s12_root;
            s12_num_reg[1] <= -NUM_W'(sq_side.b) + s12_root;
        end
    end

    // ---------------- stage 13: numerator magnitudes ----------------
    sq_side_t         s13_side_reg;
    logic [NM_W-1:0]  s13_nm_reg [2];
    logic [1:0]       s13_nneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s13_side_reg <= s12_side_reg;
            for (int k = 0; k < 2; k++)
            begin
                s13_nneg_reg[k] <= s12_num_reg[k][NUM_W-1];
                s13_nm_reg[k]   <= s12_num_reg[k][NUM_W-1] ? NM_W'(-s12_num_reg[k])
                                                           : NM_W'(s12_num_reg[k]);
            end
        end
    end

    // ---------------- stage 14: |e| times |numerator|, partial products ----------------
    hit_status_t          s14_status_reg;
    logic [A_W-1:0]       s14_a_reg;
    logic [WW-1:0]        s14_w_reg [3];
    logic                 s14_neg_reg [2][3];
    logic [EW+NH_W-1:0]   s14_ph_reg [2][3];
    logic [EW+LO_W-1:0]   s14_pl_reg [2][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s14_status_reg <= s13_side_reg.status;
            s14_a_reg      <= s13_side_reg.a;
            for (int i = 0; i < 3; i++)
                s14_w_reg[i] <= s13_side_reg.w[i];
            for (int k = 0; k < 2; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s14_neg_reg[k][i] <= s13_side_reg.dneg[i] ^ s13_nneg_reg[k];
                    s14_ph_reg[k][i]  <= (EW+NH_W)'(s13_side_reg.emag[i])
                                       * (EW+NH_W)'(s13_nm_reg[k][NM_W-1:LO_W]);
                    s14_pl_reg[k][i]  <= (EW+LO_W)'(s13_side_reg.emag[i])
                                       * (EW+LO_W)'(s13_nm_reg[k][LO_W-1:0]);
                end
            end
        end
    end

    // ---------------- stage 15: full dividends ----------------
    dv_side_t       s15_side_reg [6];
    logic [N_W-1:0] s15_n_reg [6];
    logic [A_W-1:0] s15_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s15_a_reg <= s14_a_reg;
            for (int k = 0; k < 2; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s15_n_reg[3*k+i]        <= (N_W'(s14_ph_reg[k][i]) << LO_W)
                                             + N_W'(s14_pl_reg[k][i]);
                    s15_side_reg[3*k+i].status <= s14_status_reg;
                    s15_side_reg[3*k+i].neg    <= s14_neg_reg[k][i];
                    s15_side_reg[3*k+i].w      <= s14_w_reg[i];
                end
            end
        end
    end

    // ---------------- dividers: offset = |e| |num| / A ----------------
    logic [Q_W-1:0] div_quo [6];
    dv_side_t       div_side [6];

    for (genvar g = 0; g < 6; g++)
    begin : g_div
        rsi_div_pipe #(
            .NUM_W  (N_W),
            .DEN_W  (A_W),
            .QUO_W  (Q_W),
            .SIDE_W ($bits(dv_side_t))
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (s15_vld_reg),
            .in_num   (s15_n_reg[g]),
            .in_den   (s15_a_reg),
            .in_side  (s15_side_reg[g]),
            .out_vld  (div_vld[g]),
            .out_quo  (div_quo[g]),
            .out_side (div_side[g])
        );
    end

    // ---------------- output stage: add offset, saturate, mask ----------------
    hit_status_t          out_status_reg;
    logic signed [CW-1:0] out_pt_reg [6];
    logic signed [CW-1:0] pt_next [6];

    always_comb
    begin
        logic signed [PT_W-1:0] off;
        logic signed [PT_W-1:0] sum;
        for (int g = 0; g < 6; g++)
        begin
            off = div_side[g].neg ? -$signed(PT_W'(div_quo[g])) : $signed(PT_W'(div_quo[g]));
            sum = PT_W'($signed(div_side[g].w)) + off;
            if (div_side[0].status != ST_HIT)
                pt_next[g] = '0;
            else if (sum > SAT_HI)
                pt_next[g] = SAT_HI[CW-1:0];
            else if (sum < SAT_LO)
                pt_next[g] = SAT_LO[CW-1:0];
            else
                pt_next[g] = sum[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_status_reg <= div_side[0].status;
            out_pt_reg     <= pt_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign hit_status = out_status_reg;
    assign near_x     = out_pt_reg[0];
    assign near_y     = out_pt_reg[1];
    assign near_z     = out_pt_reg[2];
    assign far_x      = out_pt_reg[3];
    assign far_y      = out_pt_reg[4];
    assign far_z      = out_pt_reg[5];

`ifndef SYNTHESIS
    // a miss or a zero direction always comes out with zero points
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit_status != 2'(ST_HIT)) |->
            (near_x == '0 && near_y == '0 && near_z == '0 &&
             far_x == '0 && far_y == '0 && far_z == '0))
        else $error("non-hit item carries nonzero points");

    // the output register takes exactly the item leaving the dividers
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (out_vld_reg == $past(div_vld[0])))
        else $error("output register lost or invented an item");
`endif

endmodule

[sim/ray_sphere_intersection_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// ray_sphere_intersection_core_tb: regression bench of the ray and sphere core
// Directed and random rays across several sphere settings and traffic patterns;
// every result is checked field by field against a bit-exact predictor.
// ============================================================================
module ray_sphere_intersection_core_tb;

    import rsi_pkg::*;

    localparam longint CYCLE_LIMIT = 600000;
    localparam int     DRAIN_WAIT  = 130;
    localparam int     HOLD_CYCLES = 400;
    localparam longint ONE         = 65536;

    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
    } ray_t;

    typedef struct packed {
        hit_status_t      st;
        logic [5:0][31:0] pt;
    } hit_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [31:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
    logic out_valid;
    logic out_ready;
    logic [1:0] hit_status;
    logic signed [31:0] near_x, near_y, near_z, far_x, far_y, far_z;

    // sphere settings as seen by the predictor
    longint      sph_cen [3];
    logic [63:0] sph_rad;

    hit_t   hit_q [$];
    int     mismatches;
    longint cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_go;
    logic   hold_on;

    ray_sphere_intersection_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .origin_z  (origin_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit_status(hit_status),
        .near_x    (near_x),
        .near_y    (near_y),
        .near_z    (near_z),
        .far_x     (far_x),
        .far_y     (far_y),
        .far_z     (far_z)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] mag64(longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // compute the near and far hit points of one ray against the sphere
    function automatic hit_t sphere_hits(ray_t r);
        hit_t         h;
        longint       w [3];
        longint       ev [3];
        longint       cr [3];
        longint       nums [2];
        longint       b;
        longint       off;
        logic [63:0]  dm [3];
        logic [63:0]  m;
        logic [63:0]  a;
        logic [63:0]  t;
        logic [63:0]  lim;
        logic [127:0] p, q, dd, c, s, prod, quo;
        int           rs, ls;
        h = '0;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = longint'($signed(r.org[i])) - sph_cen[i];
            dm[i] = mag64(longint'($signed(r.dir[i])));
            if (dm[i] > m)
                m = dm[i];
        end
        if (m == 0)
        begin
            h.st = ST_DEGEN;
            return h;
        end
        // scale the direction by a power of two into DIR_BITS
        lim = 64'd1 << DIR_BITS;
        rs = 0;
        ls = 0;
        if (m >= lim)
            while ((m >> rs) >= lim) rs++;
        else
            while ((m << ls) < (lim >> 1)) ls++;
        a = 0;
        b = 0;
        p = 0;
        q = 0;
        for (int i = 0; i < 3; i++)
        begin
            dm[i] = (dm[i] >> rs) << ls;
            ev[i] = ($signed(r.dir[i]) < 0) ? -longint'(dm[i]) : longint'(dm[i]);
            a += dm[i] * dm[i];
            b += w[i] * ev[i];
            t = dm[i] * sph_rad;
            p += 128'(t) * 128'(t);
        end
        cr[0] = w[1] * ev[2] - w[2] * ev[1];
        cr[1] = w[2] * ev[0] - w[0] * ev[2];
        cr[2] = w[0] * ev[1] - w[1] * ev[0];
        for (int i = 0; i < 3; i++)
            q += 128'(mag64(cr[i])) * 128'(mag64(cr[i]));
        if (p < q)
        begin
            h.st = ST_MISS;
            return h;
        end
        // floor square root of the discriminant
        dd = p - q;
        s = 0;
        for (int bit_i = 62; bit_i >= 0; bit_i--)
        begin
            c = s | (128'd1 << bit_i);
            if (!(dd < c * c))
                s = c;
        end
        nums[0] = -b - longint'(s[63:0]);
        nums[1] = -b + longint'(s[63:0]);
        for (int k = 0; k < 2; k++)
            for (int i = 0; i < 3; i++)
            begin
                prod = 128'(mag64(ev[i])) * 128'(mag64(nums[k]));
                quo = prod / 128'(a);
                if (quo > (128'd1 << 62))
                    quo = 128'd1 << 62;
                off = ((ev[i] < 0) != (nums[k] < 0)) ? -longint'(quo[63:0])
                                                     : longint'(quo[63:0]);
                h.pt[3 * k + i] = sat32(w[i] + off);
            end
        h.st = ST_HIT;
        return h;
    endfunction

    // count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // hold off the result side for a long stretch on request
    always
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
        hold_go = 1'b0;
    end

    // check each taken result, then drive ready for the next cycle
    always @(posedge clk)
    begin
        hit_t got;
        hit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.st = hit_status_t'(hit_status);
            got.pt = {far_z, far_y, far_x, near_z, near_y, near_x};
            if (hit_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: %h", $realtime, got);
            end
            else
            begin
                want = hit_q.pop_front();
                if (got.st !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: status exp %0d got %0d", $realtime,
                                 want.st, got.st);
                end
                for (int i = 0; i < 6; i++)
                    if (got.pt[i] !== want.pt[i])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: point field %0d exp %h got %h",
                                     $realtime, i, want.pt[i], got.pt[i]);
                    end
            end
        end
        out_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    // write one sphere register while the core is empty
    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_RADIUS)
            sph_rad = {33'd0, val[30:0]};
        else
            sph_cen[idx] = longint'($signed(val));
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
    endtask

    // send one ray item, idling first at the current rate
    task automatic send_ray(ray_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        {origin_z, origin_y, origin_x} <= r.org;
        {dir_z, dir_y, dir_x} <= r.dir;
        do @(posedge clk); while (!in_ready);
        hit_q.push_back(sphere_hits(r));
    endtask

    task automatic send_xyz(longint ox, longint oy, longint oz,
                            longint dx, longint dy, longint dz);
        ray_t r;
        r.org = {sat32(oz), sat32(oy), sat32(ox)};
        r.dir = {sat32(dz), sat32(dy), sat32(dx)};
        send_ray(r);
    endtask

    // wait until every expected result has come and the pipeline is quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (hit_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic longint rand_dir_comp();
        case ($urandom_range(5))
            0: return 0;
            1: return longint'($signed($urandom_range(0, 511))) - 256;
            2: return $urandom_range(1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
            3: return longint'($signed($urandom_range(0, 4 * 65536))) - 2 * 65536;
            default: return longint'($signed($urandom()));
        endcase
    endfunction

    // aimed rays start near the sphere; the rest are raw noise
    function automatic ray_t rand_ray();
        ray_t   r;
        longint span;
        if ($urandom_range(99) < 65)
        begin
            span = 2 * longint'(sph_rad) + ONE;
            if (span > 64'sh7FFF_FFFF)
                span = 64'sh7FFF_FFFF;
            for (int i = 0; i < 3; i++)
            begin
                r.org[i] = sat32(sph_cen[i] + longint'($urandom_range(0, span)) - span / 2);
                r.dir[i] = sat32(rand_dir_comp());
            end
            if ($urandom_range(49) == 0)
                r.dir = '0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.org[i] = $urandom();
                r.dir[i] = $urandom();
            end
        end
        return r;
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_ray(rand_ray());
    endtask

    // extremes, every status and the special cases at the unit sphere
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_xyz(ONE, 2 * ONE, 3 * ONE, 0, 0, 0);
        send_xyz(0, 2 * ONE, 0, ONE, 0, 0);
        send_xyz(-5 * ONE, ONE, 0, ONE, 0, 0);
        send_xyz(-5 * ONE, 0, 0, ONE, 0, 0);
        send_xyz(0, 0, 0, 0, 0, -ONE);
        send_xyz(ONE / 2, -ONE / 3, 0, -1, 2, -3);
        send_xyz(0, 0, -7 * ONE, 1, 0, 1);
        send_xyz(0, 0, 0, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
        send_xyz(0, 0, 0, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000);
        send_xyz(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, -1, -1, -1);
        send_xyz(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 1, 1, 1);
        send_xyz(64'sh7FFF_FFFF, 0, 0, -64'sh8000_0000, 0, 0);
        send_xyz(-64'sh8000_0000, 0, 0, 0, 0, 64'sh7FFF_FFFF);
        send_xyz(0, ONE, 0, 0, 0, ONE);
        drain();
    endtask

    // wide center and radius settings, then a zero radius sphere
    task automatic test_sphere_extremes();
        set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
        send_xyz(64'sh7FFF_FFFF, -64'sh8000_0000, 0, -ONE, ONE, 0);
        send_xyz(-64'sh8000_0000, 64'sh7FFF_FFFF, 0, 0, 0, ONE);
        send_xyz(0, 0, 0, 64'sh7FFF_FFFF, -64'sh8000_0000, 1);
        send_xyz(-64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 0, 0, 0);
        drain();
        set_sphere(32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 32'h0000_0000);
        send_xyz(-4 * ONE, -2 * ONE, 3 * ONE, ONE, 0, 0);
        send_xyz(ONE, -2 * ONE, 3 * ONE, 0, ONE, 0);
        send_xyz(-4 * ONE, -ONE, 3 * ONE, ONE, 0, 0);
        drain();
    endtask

    // stall the result side so the core fills and stops taking rays
    task automatic test_backpressure();
        set_sphere(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0002_0000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go = 1'b1;
        send_random(160);
        drain();
        send_idle_pct = 30;
        send_random(20);
        drain();
    endtask

    // random traffic under each idle and stall pattern and sphere setting
    task automatic test_random_phases();
        int idle_set  [4] = '{0, 77, 0, 11};
        int stall_set [4] = '{0, 0, 77, 11};
        set_sphere(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            send_random(80);
            drain();
            set_sphere($urandom(), $urandom(), $urandom(), $urandom_range(0, 1 << 24));
            send_random(80);
            drain();
            if (ph == 1)
                set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            else
                set_sphere($urandom(), $urandom(), $urandom(), $urandom() >> 1);
            send_random(8);
            drain();
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = REG_CENTER_X;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        origin_x       = '0;
        origin_y       = '0;
        origin_z       = '0;
        dir_x          = '0;
        dir_y          = '0;
        dir_z          = '0;
        out_ready      = 1'b0;
        hold_go        = 1'b0;
        hold_on        = 1'b0;
        mismatches     = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sph_cen[0]     = 0;
        sph_cen[1]     = 0;
        sph_cen[2]     = 0;
        sph_rad        = 64'd65536;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_sphere_extremes();
        test_backpressure();
        test_random_phases();

        drain();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
